@@ rtl/mbrr_pkg.sv @@
// ----------------------------------------------------------------------------
// mbrr_pkg: shared types and constants for the register read server
// Item structs, operation and exception codes, CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbrr_pkg;

  localparam int STORE_WORDS = 128;
  localparam int STORE_AW    = $clog2(STORE_WORDS);

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [15:0] STORE_RESET = 16'hFFFF;
  localparam logic [15:0] MAX_COUNT   = 16'd125;
  localparam logic [7:0]  EXC_FLAG    = 8'h80;
  localparam logic [7:0]  FUNC_READ   = 8'd3;
  localparam logic [3:0]  FRAME_LEN   = 4'd8;
  localparam logic [3:0]  CRC_START   = 4'd6;
  localparam logic [3:0]  CNT_OVER    = 4'd9;
  localparam logic [8:0]  HDR_LEN     = 9'd3;

  typedef enum logic [1:0] {
    OP_RX_BYTE  = 2'd0,
    OP_STORE_WR = 2'd1,
    OP_TX_SLOT  = 2'd2
  } op_t;

  localparam logic [1:0] EXC_BAD_FUNC  = 2'd1;
  localparam logic [1:0] EXC_BAD_ADDR  = 2'd2;
  localparam logic [1:0] EXC_BAD_COUNT = 2'd3;

  localparam logic CFG_UNIT_ADDR = 1'b0;
  localparam logic CFG_BASE_ADDR = 1'b1;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  rx_byte;
    logic        rx_frame_end;
    logic [6:0]  store_index;
    logic [15:0] store_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
  } out_item_t;

  // response launch from the frame decoder
  typedef struct packed {
    logic                valid;
    logic                is_exc;
    logic [1:0]          code;
    logic [7:0]          func;
    logic [STORE_AW-1:0] offset;
    logic [6:0]          total;
  } start_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/mbrr_ram.sv @@
// ----------------------------------------------------------------------------
// mbrr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mbrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/mbrr_rx.sv @@
// ----------------------------------------------------------------------------
// mbrr_rx: request frame collector and decoder
// Buffers up to eight bytes, runs the request CRC, validates at frame end.
// ----------------------------------------------------------------------------
module mbrr_rx import mbrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  in_item_t    item,
  input  logic [7:0]  unit_addr,
  input  logic [15:0] base_addr,
  input  logic        resp_active,
  output start_t      start
);

  logic [7:0]  bytes_r [8];
  logic [7:0]  bytes_upd [8];
  logic [7:0]  bytes_nxt [8];
  logic [3:0]  cnt_r, cnt_upd, cnt_nxt;
  logic [15:0] crc_r, crc_upd, crc_nxt;
  logic        is_rx;
  logic [15:0] addr, count, got, diff;
  logic [16:0] addr_end, limit;
  logic        frame_ok;

  always_comb begin
    bytes_upd = bytes_r;
    cnt_upd   = cnt_r;
    crc_upd   = crc_r;
    if (cnt_r < FRAME_LEN) begin
      bytes_upd[cnt_r[2:0]] = item.rx_byte;
      if (cnt_r < CRC_START) begin
        crc_upd = crc_byte(crc_r, item.rx_byte);
      end
      cnt_upd = cnt_r + 4'd1;
    end else begin
      cnt_upd = CNT_OVER;
    end

    is_rx = fire && (item.operation == OP_RX_BYTE);
    if (is_rx) begin
      bytes_nxt = bytes_upd;
      cnt_nxt   = item.rx_frame_end ? 4'd0 : cnt_upd;
      crc_nxt   = item.rx_frame_end ? CRC_INIT : crc_upd;
    end else begin
      bytes_nxt = bytes_r;
      cnt_nxt   = cnt_r;
      crc_nxt   = crc_r;
    end
  end

  // decode on the frame as it stands with this byte included
  always_comb begin
    addr     = {bytes_upd[2], bytes_upd[3]};
    count    = {bytes_upd[4], bytes_upd[5]};
    got      = {bytes_upd[7], bytes_upd[6]};
    diff     = addr - base_addr;
    addr_end = {1'b0, addr} + {1'b0, count};
    limit    = {1'b0, base_addr} + 17'(STORE_WORDS);
    frame_ok = is_rx && item.rx_frame_end && (cnt_upd == FRAME_LEN) && !resp_active &&
               (got == crc_upd) && (bytes_upd[0] != 8'd0) && (bytes_upd[0] == unit_addr);

    start.valid  = frame_ok;
    start.func   = bytes_upd[1];
    start.offset = '0;
    start.total  = '0;
    start.is_exc = 1'b1;
    start.code   = 2'd0;
    if (bytes_upd[1] != FUNC_READ) begin
      start.code = EXC_BAD_FUNC;
    end else if ((count == 16'd0) || (count > MAX_COUNT)) begin
      start.code = EXC_BAD_COUNT;
    end else if ((addr < base_addr) || (addr_end > limit)) begin
      start.code = EXC_BAD_ADDR;
    end else begin
      start.is_exc = 1'b0;
      start.offset = diff[STORE_AW-1:0];
      start.total  = count[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 4'd0;
      crc_r <= CRC_INIT;
    end else begin
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
  end

endmodule

@@ rtl/mbrr_tx.sv @@
// ----------------------------------------------------------------------------
// mbrr_tx: response sequencer
// Emits one response byte per transmit slot and runs the response CRC.
// ----------------------------------------------------------------------------
module mbrr_tx import mbrr_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  in_item_t            item,
  input  start_t              start,
  input  logic [7:0]          unit_addr,
  input  logic [15:0]         rd_word,
  output logic                active,
  output logic                res_valid,
  output out_item_t           res,
  output logic [STORE_AW-1:0] rd_addr
);

  logic                active_r, active_nxt;
  logic                exc_r, exc_nxt;
  logic [1:0]          code_r, code_nxt;
  logic [7:0]          func_r, func_nxt;
  logic [STORE_AW-1:0] off_r, off_nxt;
  logic [6:0]          tot_r, tot_nxt;
  logic [8:0]          pos_r, pos_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [8:0]          len_m2, k, k_nxt, idx_sum;
  logic [7:0]          payload, tx_byte;
  logic                slot, last;

  always_comb begin
    len_m2 = exc_r ? HDR_LEN : (HDR_LEN + {1'b0, tot_r, 1'b0});
    k      = pos_r - HDR_LEN;
    case (pos_r)
      9'd0:    payload = unit_addr;
      9'd1:    payload = exc_r ? (func_r | EXC_FLAG) : func_r;
      9'd2:    payload = exc_r ? {6'd0, code_r} : {tot_r, 1'b0};
      default: payload = k[0] ? rd_word[7:0] : rd_word[15:8];
    endcase

    slot       = fire && (item.operation == OP_TX_SLOT) && active_r;
    active_nxt = active_r;
    exc_nxt    = exc_r;
    code_nxt   = code_r;
    func_nxt   = func_r;
    off_nxt    = off_r;
    tot_nxt    = tot_r;
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    tx_byte    = payload;
    last       = 1'b0;

    if (slot) begin
      if (pos_r < len_m2) begin
        crc_nxt = crc_byte(crc_r, payload);
      end else if (pos_r == len_m2) begin
        tx_byte = crc_r[7:0];
      end else begin
        tx_byte = crc_r[15:8];
        last    = 1'b1;
      end
      if (last) begin
        active_nxt = 1'b0;
        pos_nxt    = 9'd0;
      end else begin
        pos_nxt = pos_r + 9'd1;
      end
    end

    if (start.valid) begin
      active_nxt = 1'b1;
      exc_nxt    = start.is_exc;
      code_nxt   = start.code;
      func_nxt   = start.func;
      off_nxt    = start.offset;
      tot_nxt    = start.total;
      pos_nxt    = 9'd0;
      crc_nxt    = CRC_INIT;
    end

    // store address for the byte after this one; the RAM read lands next cycle
    k_nxt   = pos_nxt - HDR_LEN;
    idx_sum = 9'(off_nxt) + {1'b0, k_nxt[8:1]};
    rd_addr = idx_sum[STORE_AW-1:0];
  end

  assign active      = active_r;
  assign res_valid   = slot;
  assign res.tx_byte = tx_byte;
  assign res.tx_last = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      exc_r    <= 1'b0;
      code_r   <= 2'd0;
      func_r   <= 8'd0;
      off_r    <= '0;
      tot_r    <= 7'd0;
      pos_r    <= 9'd0;
      crc_r    <= CRC_INIT;
    end else begin
      active_r <= active_nxt;
      exc_r    <= exc_nxt;
      code_r   <= code_nxt;
      func_r   <= func_nxt;
      off_r    <= off_nxt;
      tot_r    <= tot_nxt;
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule

@@ rtl/modbus_rtu_register_read_server.sv @@
// ----------------------------------------------------------------------------
// modbus_rtu_register_read_server: Modbus RTU holding register read responder
//
//   channel | dir | handshake              | payload
//   in_     | in  | in_valid / in_ready    | in_data  (in_item_t)
//   out_    | out | out_valid / out_ready  | out_data (out_item_t)
//   cfg_    | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One request per cycle unless the output stalls: a request is processed from
// the input register; its response byte (if any) goes to the output register.
// Store reads use a registered RAM port, addressed the cycle before use.
// Reset clears the store valid bits at once; unwritten entries read FFFF.
// A held output register stalls the input register and so holds in_ready low.
// ----------------------------------------------------------------------------
module modbus_rtu_register_read_server import mbrr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic                   in_valid_r;
  in_item_t               in_r;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r;
  logic [7:0]             unit_r;
  logic [15:0]            base_r;
  logic                   fire;
  start_t                 start;
  logic                   resp_active;
  logic                   res_valid;
  out_item_t              res;
  logic [STORE_AW-1:0]    rd_addr, raddr_r;
  logic [15:0]            ram_q, rd_word, byp_data_r;
  logic                   byp_hit_r;
  logic                   ram_we;
  logic [STORE_AW-1:0]    waddr;
  logic [STORE_WORDS-1:0] valid_r;

  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign out_valid_nxt = fire ? res_valid : (out_valid_r && !out_ready);

  assign waddr  = in_r.store_index[STORE_AW-1:0];
  assign ram_we = fire && (in_r.operation == OP_STORE_WR) &&
                  ({1'b0, in_r.store_index} < 8'(STORE_WORDS));

  assign rd_word = byp_hit_r ? byp_data_r : (valid_r[raddr_r] ? ram_q : STORE_RESET);

  mbrr_rx u_rx (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item       (in_r),
    .unit_addr  (unit_r),
    .base_addr  (base_r),
    .resp_active(resp_active),
    .start      (start)
  );

  mbrr_tx u_tx (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (fire),
    .item     (in_r),
    .start    (start),
    .unit_addr(unit_r),
    .rd_word  (rd_word),
    .active   (resp_active),
    .res_valid(res_valid),
    .res      (res),
    .rd_addr  (rd_addr)
  );

  mbrr_ram #(
    .WIDTH(16),
    .DEPTH(STORE_WORDS)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(waddr),
    .wdata(in_r.store_value),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      unit_r      <= 8'd1;
      base_r      <= 16'd40000;
      valid_r     <= '0;
      byp_hit_r   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_UNIT_ADDR: unit_r <= cfg_data[7:0];
          CFG_BASE_ADDR: base_r <= cfg_data;
          default:       unit_r <= unit_r;
        endcase
      end
      if (ram_we) begin
        valid_r[waddr] <= 1'b1;
      end
      // write and read of the same entry on one edge: forward the new value
      byp_hit_r <= ram_we && (waddr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
    if (fire && res_valid) begin
      out_r <= res;
    end
    raddr_r    <= rd_addr;
    byp_data_r <= in_r.store_value;
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !fire |=> in_valid_r && $stable(in_r))
    else $error("input register changed while stalled");

  a_res_op: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid |-> in_r.operation == OP_TX_SLOT)
    else $error("response byte from a non-transmit request");

  a_byp: assert property (@(posedge clk) disable iff (!rst_n)
    byp_hit_r |-> $past(ram_we))
    else $error("store bypass without a write");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start.valid |-> !resp_active && in_r.operation == OP_RX_BYTE)
    else $error("response launched while busy");

endmodule

@@ tb/tb_modbus_rtu_register_read_server.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for modbus_rtu_register_read_server
// Drives request bytes, store writes and transmit slots through the valid/ready
// request channel. A cycle-free model of the server predicts every response
// byte, and each byte taken from the output channel is checked against it.
// ----------------------------------------------------------------------------
module tb;
  import mbrr_pkg::*;

  localparam logic [1:0] OP_RESERVED   = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         DRAIN_LIMIT   = 20_000;
  localparam int         RANDOM_ITEMS  = 600;
  localparam int         PHASES        = 4;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         EXC_LEN       = 5;

  typedef logic [7:0] frame_q_t[$];

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_UNIT_ADDR;
  logic [15:0] cfg_data  = '0;

  modbus_rtu_register_read_server u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // server model state
  logic [15:0] m_store [STORE_WORDS];
  logic [7:0]  m_req [8];
  logic [3:0]  m_rcv_cnt;
  logic [15:0] m_req_crc;
  logic        m_active;
  logic        m_is_exc;
  logic [1:0]  m_exc_code;
  logic [7:0]  m_func;
  int unsigned m_word_off;
  int unsigned m_word_tot;
  int unsigned m_byte_pos;
  logic [15:0] m_resp_crc;
  logic [7:0]  m_unit;
  logic [15:0] m_base;

  out_item_t tx_expect_q[$];

  int  n_fail     = 0;
  int  n_checked  = 0;
  int  n_work     = 0;
  int  n_answered = 0;
  int  n_cfg      = 0;
  int  cycle_count = 0;
  bit  send_gaps  = 1'b1;
  bit  ready_gaps = 1'b1;
  int  hold_len   = 0;
  int  hold_seq   = 0;
  int  hold_seen  = 0;
  int  ready_wait = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, plus a long hold-off when the test asks for one
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      ready_wait = hold_len;
      out_ready <= 1'b0;
    end else if (ready_wait > 0) begin
      ready_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (ready_gaps) ready_wait = gap_len();
    end
  end

  always @(posedge clk) begin : check_tx
    out_item_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (tx_expect_q.size() == 0) begin
        $error("unexpected response byte 0x%02h (last %0b)", out_data.tx_byte,
               out_data.tx_last);
        n_fail++;
      end else begin
        want = tx_expect_q.pop_front();
        n_checked++;
        if (out_data.tx_byte !== want.tx_byte) begin
          $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, out_data.tx_byte);
          n_fail++;
        end
        if (out_data.tx_last !== want.tx_last) begin
          $error("tx_last: expected %0b, got %0b", want.tx_last, out_data.tx_last);
          n_fail++;
        end
      end
    end
  end

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ data[k];
      r = r >> 1;
      if (fb) r = r ^ CRC_POLY;
    end
    return r;
  endfunction

  task automatic model_reset();
    foreach (m_store[i]) m_store[i] = STORE_RESET;
    foreach (m_req[i]) m_req[i] = '0;
    m_rcv_cnt  = '0;
    m_req_crc  = CRC_INIT;
    m_active   = 1'b0;
    m_is_exc   = 1'b0;
    m_exc_code = '0;
    m_func     = '0;
    m_word_off = 0;
    m_word_tot = 0;
    m_byte_pos = 0;
    m_resp_crc = CRC_INIT;
    m_unit     = 8'd1;
    m_base     = 16'd40000;
  endtask

  // decide whether a completed request frame starts a response
  task automatic close_frame();
    logic [15:0] rx_crc;
    logic [15:0] addr;
    logic [15:0] cnt;
    if (m_rcv_cnt != FRAME_LEN || m_active) return;
    rx_crc = {m_req[7], m_req[6]};
    if (rx_crc != m_req_crc || m_req[0] == 8'h00 || m_req[0] != m_unit) return;
    addr = {m_req[2], m_req[3]};
    cnt  = {m_req[4], m_req[5]};
    m_func     = m_req[1];
    m_active   = 1'b1;
    m_is_exc   = 1'b1;
    m_exc_code = '0;
    m_word_off = 0;
    m_word_tot = 0;
    m_byte_pos = 0;
    m_resp_crc = CRC_INIT;
    n_answered++;
    if (m_func != FUNC_READ) begin
      m_exc_code = EXC_BAD_FUNC;
    end else if (cnt == 16'd0 || cnt > MAX_COUNT) begin
      m_exc_code = EXC_BAD_COUNT;
    end else if (addr < m_base ||
                 32'(addr) + 32'(cnt) > 32'(m_base) + 32'(STORE_WORDS)) begin
      m_exc_code = EXC_BAD_ADDR;
    end else begin
      m_is_exc   = 1'b0;
      m_word_off = 32'(addr - m_base);
      m_word_tot = 32'(cnt);
    end
  endtask

  function automatic logic [7:0] response_payload(input int unsigned pos);
    int unsigned k;
    logic [15:0] w;
    if (pos == 0) return m_unit;
    if (pos == 1) return m_is_exc ? (m_func | EXC_FLAG) : m_func;
    if (pos == 2) return m_is_exc ? {6'd0, m_exc_code} : 8'(2 * m_word_tot);
    k = pos - 3;
    w = m_store[m_word_off + (k >> 1)];
    return k[0] ? w[7:0] : w[15:8];
  endfunction

  task automatic server_step(input in_item_t it);
    int unsigned len;
    out_item_t   o;
    case (it.operation)
      OP_RX_BYTE: begin
        n_work++;
        if (m_rcv_cnt < FRAME_LEN) begin
          m_req[m_rcv_cnt[2:0]] = it.rx_byte;
          if (m_rcv_cnt < CRC_START) m_req_crc = crc16_update(m_req_crc, it.rx_byte);
          m_rcv_cnt++;
        end else begin
          m_rcv_cnt = CNT_OVER;
        end
        if (it.rx_frame_end) begin
          close_frame();
          m_rcv_cnt = '0;
          m_req_crc = CRC_INIT;
        end
      end
      OP_STORE_WR: begin
        n_work++;
        m_store[it.store_index] = it.store_value;
      end
      OP_TX_SLOT: begin
        if (m_active) begin
          n_work++;
          len = m_is_exc ? EXC_LEN : EXC_LEN + 2 * m_word_tot;
          o.tx_last = 1'b0;
          if (m_byte_pos < len - 2) begin
            o.tx_byte = response_payload(m_byte_pos);
            m_resp_crc = crc16_update(m_resp_crc, o.tx_byte);
          end else if (m_byte_pos == len - 2) begin
            o.tx_byte = m_resp_crc[7:0];
          end else begin
            o.tx_byte = m_resp_crc[15:8];
            o.tx_last = 1'b1;
          end
          if (o.tx_last) begin
            m_active = 1'b0;
            m_byte_pos = 0;
          end else begin
            m_byte_pos++;
          end
          tx_expect_q.push_back(o);
        end
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input in_item_t it);
    int gap;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    server_step(it);
    gap = send_gaps ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // unused fields carry random noise
  function automatic in_item_t noise_item(input logic [1:0] op);
    in_item_t it;
    it.operation    = op;
    it.rx_byte      = 8'($urandom_range(0, 255));
    it.rx_frame_end = 1'($urandom_range(0, 1));
    it.store_index  = 7'($urandom_range(0, 127));
    it.store_value  = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic rx_byte_send(input logic [7:0] b, input logic last);
    in_item_t it;
    it = noise_item(OP_RX_BYTE);
    it.rx_byte = b;
    it.rx_frame_end = last;
    send_item(it);
  endtask

  task automatic store_write(input int idx, input logic [15:0] val);
    in_item_t it;
    it = noise_item(OP_STORE_WR);
    it.store_index = 7'(idx);
    it.store_value = val;
    send_item(it);
  endtask

  task automatic tx_slot();
    send_item(noise_item(OP_TX_SLOT));
  endtask

  task automatic send_frame(input frame_q_t f);
    foreach (f[i]) rx_byte_send(f[i], i == f.size() - 1);
  endtask

  function automatic frame_q_t read_frame(input logic [7:0] unit, input logic [7:0] func,
                                          input logic [15:0] addr, input logic [15:0] cnt);
    frame_q_t    f;
    logic [15:0] c;
    f = '{unit, func, addr[15:8], addr[7:0], cnt[15:8], cnt[7:0]};
    c = CRC_INIT;
    foreach (f[i]) c = crc16_update(c, f[i]);
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    return f;
  endfunction

  task automatic drain_response();
    while (m_active) tx_slot();
  endtask

  task automatic query(input logic [7:0] unit, input logic [7:0] func,
                       input logic [15:0] addr, input logic [15:0] cnt);
    send_frame(read_frame(unit, func, addr, cnt));
    drain_response();
  endtask

  // bring the server to idle: no partial frame, no response, nothing in flight
  task automatic quiesce();
    int waited;
    if (m_rcv_cnt != 0) rx_byte_send(8'($urandom_range(0, 255)), 1'b1);
    drain_response();
    in_valid <= 1'b0;
    waited = 0;
    while (tx_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (tx_expect_q.size() != 0) begin
      $error("%0d response bytes never arrived", tx_expect_q.size());
      n_fail++;
      tx_expect_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_register(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_UNIT_ADDR) m_unit = val[7:0];
    else m_base = val;
    n_cfg++;
    repeat (2) @(posedge clk);
  endtask

  task automatic test_reset_store();
    set_register(CFG_UNIT_ADDR, 16'd1);
    set_register(CFG_BASE_ADDR, 16'd40000);
    query(m_unit, FUNC_READ, m_base, 16'd2);
  endtask

  task automatic test_store_extremes();
    store_write(0, 16'h0000);
    store_write(1, 16'hFFFF);
    store_write(STORE_WORDS - 1, 16'hA55A);
    query(m_unit, FUNC_READ, m_base, 16'd2);
    query(m_unit, FUNC_READ, 16'(m_base + STORE_WORDS - 1), 16'd1);
  endtask

  task automatic test_exceptions();
    query(m_unit, 8'h00, m_base, 16'd1);
    query(m_unit, 8'hFF, m_base, 16'd1);
    query(m_unit, 8'h10, m_base, 16'd1);
    query(m_unit, FUNC_READ, m_base, 16'd0);
    query(m_unit, FUNC_READ, m_base, MAX_COUNT + 16'd1);
    query(m_unit, FUNC_READ, m_base, 16'hFFFF);
    query(m_unit, FUNC_READ, m_base, MAX_COUNT);
    query(m_unit, FUNC_READ, m_base - 16'd1, 16'd1);
    query(m_unit, FUNC_READ, 16'(m_base + STORE_WORDS - 1), 16'd2);
  endtask

  task automatic test_dropped_frames();
    frame_q_t f;
    in_item_t it;
    f = read_frame(m_unit, FUNC_READ, m_base, 16'd1);
    f[7] = f[7] ^ 8'h01;
    send_frame(f);
    tx_slot();
    f = read_frame(m_unit, FUNC_READ, m_base, 16'd1);
    void'(f.pop_back());
    send_frame(f);
    f = read_frame(m_unit, FUNC_READ, m_base, 16'd1);
    f.push_back(8'h00);
    f.push_back(8'hFF);
    send_frame(f);
    send_frame(read_frame(8'h00, FUNC_READ, m_base, 16'd1));
    send_frame(read_frame(m_unit + 8'd1, FUNC_READ, m_base, 16'd1));
    tx_slot();
    // frame end flag on other request kinds must not cut the frame short
    f = read_frame(m_unit, FUNC_READ, m_base + 16'd3, 16'd1);
    for (int i = 0; i < 4; i++) rx_byte_send(f[i], 1'b0);
    it = noise_item(OP_STORE_WR);
    it.rx_frame_end = 1'b1;
    send_item(it);
    it = noise_item(OP_TX_SLOT);
    it.rx_frame_end = 1'b1;
    send_item(it);
    it = noise_item(OP_RESERVED);
    it.rx_frame_end = 1'b1;
    send_item(it);
    for (int i = 4; i < 8; i++) rx_byte_send(f[i], i == 7);
    drain_response();
  endtask

  task automatic test_busy_server();
    store_write(5, 16'h1234);
    store_write(6, 16'h5678);
    send_frame(read_frame(m_unit, FUNC_READ, m_base + 16'd5, 16'd2));
    repeat (4) tx_slot();
    // live update: the low byte of word 5 is still to go out
    store_write(5, 16'hABCD);
    store_write(6, 16'h0F0F);
    send_frame(read_frame(m_unit, FUNC_READ, m_base, 16'd1));
    drain_response();
    tx_slot();
    query(m_unit, FUNC_READ, m_base + 16'd5, 16'd2);
  endtask

  task automatic test_backpressure();
    send_gaps = 1'b0;
    hold_len = HOLD_CYCLES;
    hold_seq++;
    send_frame(read_frame(m_unit, FUNC_READ, m_base + 16'd10, 16'd40));
    drain_response();
    quiesce();
    send_gaps = 1'b1;
  endtask

  task automatic run_random_traffic(input int target);
    int          stop_at;
    int          r;
    int          n;
    int          off;
    int          maxc;
    frame_q_t    f;
    logic [7:0]  unit;
    logic [7:0]  func;
    logic [15:0] addr;
    logic [15:0] cnt;
    stop_at = n_work + target;
    while (n_work < stop_at) begin
      if ($urandom_range(0, 9) == 0) send_gaps = !send_gaps;
      if ($urandom_range(0, 9) == 0) ready_gaps = !ready_gaps;
      r = $urandom_range(0, 99);
      if (r < 60) begin
        n = $urandom_range(0, 99);
        unit = (n < 85) ? m_unit : ((n < 90) ? 8'h00 : 8'($urandom_range(0, 255)));
        func = ($urandom_range(0, 99) < 85) ? FUNC_READ : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 80) begin
          off = $urandom_range(0, STORE_WORDS - 1);
          maxc = STORE_WORDS - off;
          if (maxc > MAX_COUNT) maxc = int'(MAX_COUNT);
          if ($urandom_range(0, 9) != 0 && maxc > 4) maxc = 4;
          cnt = 16'($urandom_range(1, maxc));
          addr = 16'(m_base + off);
        end else begin
          addr = 16'($urandom_range(0, 65535));
          case ($urandom_range(0, 3))
            0: cnt = 16'd0;
            1: cnt = MAX_COUNT + 16'd1;
            2: cnt = 16'($urandom_range(0, 65535));
            default: cnt = 16'($urandom_range(1, MAX_COUNT));
          endcase
        end
        f = read_frame(unit, func, addr, cnt);
        if ($urandom_range(0, 9) == 0) f[$urandom_range(0, 7)] ^= 8'(1 << $urandom_range(0, 7));
        n = $urandom_range(0, 19);
        if (n == 0) void'(f.pop_back());
        else if (n == 1) repeat ($urandom_range(1, 4)) f.push_back(8'($urandom_range(0, 255)));
        send_frame(f);
        n = $urandom_range(0, 99);
        if (n < 75) drain_response();
        else if (n < 90) repeat ($urandom_range(1, 10)) tx_slot();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4))
          store_write($urandom_range(0, STORE_WORDS - 1), 16'($urandom_range(0, 65535)));
      end else if (r < 85) begin
        repeat ($urandom_range(1, 8)) tx_slot();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6))
          rx_byte_send(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      end else begin
        send_item(noise_item(2'($urandom_range(0, 3))));
      end
    end
  endtask

  task automatic test_random_phases();
    logic [7:0]  unit;
    logic [15:0] base;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin unit = 8'd247; base = 16'd0; end
        1: begin unit = 8'd1; base = 16'hFFFF; end
        default: begin
          unit = 8'($urandom_range(1, 247));
          base = 16'($urandom_range(0, 65535));
        end
      endcase
      quiesce();
      set_register(CFG_UNIT_ADDR, {8'($urandom_range(0, 255)), unit});
      set_register(CFG_BASE_ADDR, base);
      run_random_traffic(RANDOM_ITEMS / PHASES);
    end
  endtask

  initial begin
    model_reset();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_store();
    test_store_extremes();
    test_exceptions();
    test_dropped_frames();
    test_busy_server();
    test_backpressure();
    test_random_phases();
    quiesce();
    $display("Run covered %0d requests, %0d answered frames, %0d register writes.",
             n_work, n_answered, n_cfg);
    $display("%0d response bytes checked, %0d mismatches.", n_checked, n_fail);
    if (n_fail == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
